@@ rtl/tda_pkg.sv @@
package tda_pkg;

  localparam int unsigned SecsW = 17;
  localparam int unsigned NanosW = 30;

  localparam logic [NanosW-1:0] NS_PER_SEC = 30'd1000000000;
  localparam logic [SecsW-1:0] SECS_PER_DAY = 17'd86400;
  localparam logic [SecsW:0] SECS_PER_TWO_DAYS = 18'd172800;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [5:0] SECS_PER_MIN = 6'd60;

  // load range limits
  localparam logic [4:0] HOUR_WRAP = 5'd24;
  localparam logic [5:0] MINUTE_LIMIT = 6'd60;
  localparam logic [5:0] SECOND_LIMIT = 6'd61;

  // Multiple of one day above 2^31 + 2; biases the seconds delta non-negative.
  localparam logic signed [33:0] DAY_BIAS = 34'sd2147558400;

  // 86400 = 675 * 128: reduce the upper bits mod 675, keep the low 7 bits.
  localparam int unsigned DayLowW = 7;
  localparam logic [9:0] DAY_ODD = 10'd675;
  localparam logic [26:0] RECIP_675 = 27'd101806633;
  localparam int unsigned Recip675Sh = 36;

  localparam logic [18:0] RECIP_3600 = 19'd298262;
  localparam int unsigned Recip3600Sh = 30;
  localparam logic [12:0] RECIP_60 = 13'd4370;
  localparam int unsigned Recip60Sh = 18;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_ADD  = 2'd1,
    CMD_SUB  = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  // range flags: bit 0 hour, 1 minute, 2 second, 3 nanosecond
  typedef struct packed {
    cmd_e              cmd;
    logic [SecsW-1:0]  load_secs;
    logic [3:0]        load_bad;
    logic [SecsW-1:0]  delta_secs;   // delta seconds mod one day
    logic [NanosW-1:0] nanos;        // load nanoseconds or delta nanos mod 1e9
  } upd_t;

  typedef struct packed {
    logic [SecsW-1:0]  day_secs;
    logic [NanosW-1:0] nanos;
    logic              error;
    logic [3:0]        bad;
  } snap_t;

  typedef struct packed {
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [5:0]        sec;
    logic [NanosW-1:0] nanos;
    logic              error;
    logic [3:0]        bad;
  } res_t;

endpackage

@@ rtl/tda_prep.sv @@
module tda_prep (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tda_pkg::cmd_e     cmd_i,
  input  logic [4:0]        load_hour_i,
  input  logic [5:0]        load_minute_i,
  input  logic [5:0]        load_second_i,
  input  logic [29:0]       load_nanosecond_i,
  input  logic [31:0]       delta_secs_i,
  input  logic [30:0]       delta_nanos_i,
  output logic              upd_valid_o,
  input  logic              upd_ready_i,
  output tda_pkg::upd_t     upd_o
);
  import tda_pkg::*;

  logic v0_q, v1_q, v2_q, v3_q;
  logic rdy0, rdy1, rdy2, rdy3;

  // stage 0: input register
  cmd_e        cmd0_q;
  logic [4:0]  hour0_q;
  logic [5:0]  min0_q;
  logic [5:0]  sec0_q;
  logic [29:0] ns0_q;
  logic [31:0] dsec0_q;
  logic [30:0] dns0_q;

  // stage 1: signed deltas folded to non-negative values
  cmd_e               cmd1_q;
  logic [SecsW-1:0]   lsecs1_q;
  logic [3:0]         lbad1_q;
  logic [25:0]        x1_q;
  logic [DayLowW-1:0] lo1_q;
  logic [29:0]        rn1_q;

  // stage 2: quotient by 675
  cmd_e               cmd2_q;
  logic [SecsW-1:0]   lsecs2_q;
  logic [3:0]         lbad2_q;
  logic [16:0]        quo2_q;
  logic [25:0]        x2_q;
  logic [DayLowW-1:0] lo2_q;
  logic [29:0]        rn2_q;

  upd_t upd3_q;

  assign rdy3 = !v3_q || upd_ready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign rdy0 = !v0_q || rdy1;
  assign in_ready_o = rdy0;
  assign upd_valid_o = v3_q;
  assign upd_o = upd3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= in_valid_i;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // stage 1 logic
  logic               is_sub;
  logic signed [31:0] dn_s, dn_e;
  logic signed [32:0] dn_w, rn_w;
  logic signed [2:0]  carry_s;
  logic signed [33:0] ds_s, ds_e, bias_sum;
  logic [4:0]         hour_eff;
  logic [SecsW-1:0]   load_secs;
  logic [3:0]         load_bad;

  always_comb begin
    is_sub = (cmd0_q == CMD_SUB);
    dn_s = 32'(signed'(dns0_q));
    dn_e = is_sub ? -dn_s : dn_s;
    dn_w = 33'(dn_e);
    // floor division of the nanosecond delta by one second
    if (dn_w >= 33'sd1000000000) begin
      carry_s = 3'sd1;
      rn_w = dn_w - 33'sd1000000000;
    end else if (dn_w >= 33'sd0) begin
      carry_s = 3'sd0;
      rn_w = dn_w;
    end else if (dn_w >= -33'sd1000000000) begin
      carry_s = -3'sd1;
      rn_w = dn_w + 33'sd1000000000;
    end else begin
      carry_s = -3'sd2;
      rn_w = dn_w + 33'sd2000000000;
    end
    ds_s = 34'(signed'(dsec0_q));
    ds_e = is_sub ? -ds_s : ds_s;
    bias_sum = ds_e + 34'(carry_s) + DAY_BIAS;

    hour_eff = (hour0_q == HOUR_WRAP) ? 5'd0 : hour0_q;
    load_bad[0] = hour0_q > HOUR_WRAP;
    load_bad[1] = min0_q >= MINUTE_LIMIT;
    load_bad[2] = sec0_q >= SECOND_LIMIT;
    load_bad[3] = ns0_q >= NS_PER_SEC;
    load_secs = SecsW'(sec0_q) + SecsW'(min0_q) * SecsW'(SECS_PER_MIN)
              + SecsW'(hour_eff) * SecsW'(SECS_PER_HOUR);
  end

  // stage 2 and 3 logic
  logic [52:0] quo_prod;
  logic [26:0] odd_prod;
  logic [25:0] odd_rem;

  always_comb begin
    quo_prod = 53'(x1_q) * 53'(RECIP_675);
    odd_prod = 27'(quo2_q) * 27'(DAY_ODD);
    odd_rem = x2_q - odd_prod[25:0];
  end

  always_ff @(posedge clk_i) begin
    if (rdy0) begin
      cmd0_q  <= cmd_i;
      hour0_q <= load_hour_i;
      min0_q  <= load_minute_i;
      sec0_q  <= load_second_i;
      ns0_q   <= load_nanosecond_i;
      dsec0_q <= delta_secs_i;
      dns0_q  <= delta_nanos_i;
    end
    if (rdy1) begin
      cmd1_q   <= cmd0_q;
      lsecs1_q <= load_secs;
      lbad1_q  <= load_bad;
      x1_q     <= bias_sum[32:DayLowW];
      lo1_q    <= bias_sum[DayLowW-1:0];
      rn1_q    <= (cmd0_q == CMD_LOAD) ? ns0_q : rn_w[29:0];
    end
    if (rdy2) begin
      cmd2_q   <= cmd1_q;
      lsecs2_q <= lsecs1_q;
      lbad2_q  <= lbad1_q;
      quo2_q   <= quo_prod[52:Recip675Sh];
      x2_q     <= x1_q;
      lo2_q    <= lo1_q;
      rn2_q    <= rn1_q;
    end
    if (rdy3) begin
      upd3_q.cmd        <= cmd2_q;
      upd3_q.load_secs  <= lsecs2_q;
      upd3_q.load_bad   <= lbad2_q;
      upd3_q.delta_secs <= {odd_rem[9:0], lo2_q};
      upd3_q.nanos      <= rn2_q;
    end
  end

endmodule

@@ rtl/tda_state.sv @@
module tda_state (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            upd_valid_i,
  output logic            upd_ready_o,
  input  tda_pkg::upd_t   upd_i,
  output logic            snap_valid_o,
  input  logic            snap_ready_i,
  output tda_pkg::snap_t  snap_o
);
  import tda_pkg::*;

  logic              vs_q;
  logic [SecsW-1:0]  day_secs_q, day_secs_d;
  logic [NanosW-1:0] nanos_q, nanos_d;
  logic              error_q, error_d;
  logic [3:0]        bad_q, bad_d;
  logic              take;

  logic [NanosW:0]   ns_sum;
  logic              ns_carry;
  logic [SecsW:0]    sec_sum;

  assign upd_ready_o = !vs_q || snap_ready_i;
  assign take = upd_valid_i && upd_ready_o;

  always_comb begin
    ns_sum = (NanosW+1)'(nanos_q) + (NanosW+1)'(upd_i.nanos);
    ns_carry = ns_sum >= (NanosW+1)'(NS_PER_SEC);
    sec_sum = (SecsW+1)'(day_secs_q) + (SecsW+1)'(upd_i.delta_secs)
            + (SecsW+1)'(ns_carry);

    day_secs_d = day_secs_q;
    nanos_d = nanos_q;
    error_d = error_q;
    bad_d = bad_q;
    case (upd_i.cmd)
      CMD_LOAD: begin
        bad_d = upd_i.load_bad;
        error_d = |upd_i.load_bad;
        day_secs_d = error_d ? '0 : upd_i.load_secs;
        nanos_d = error_d ? '0 : upd_i.nanos;
      end
      CMD_ADD, CMD_SUB: begin
        // hold everything while a failed load is latched
        if (!error_q) begin
          nanos_d = ns_carry ? NanosW'(ns_sum - (NanosW+1)'(NS_PER_SEC))
                             : ns_sum[NanosW-1:0];
          if (sec_sum >= SECS_PER_TWO_DAYS) begin
            day_secs_d = SecsW'(sec_sum - SECS_PER_TWO_DAYS);
          end else if (sec_sum >= (SecsW+1)'(SECS_PER_DAY)) begin
            day_secs_d = SecsW'(sec_sum - (SecsW+1)'(SECS_PER_DAY));
          end else begin
            day_secs_d = sec_sum[SecsW-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q       <= 1'b0;
      day_secs_q <= '0;
      nanos_q    <= '0;
      error_q    <= 1'b0;
      bad_q      <= '0;
    end else begin
      if (upd_ready_o) vs_q <= upd_valid_i;
      if (take) begin
        day_secs_q <= day_secs_d;
        nanos_q    <= nanos_d;
        error_q    <= error_d;
        bad_q      <= bad_d;
      end
    end
  end

  assign snap_valid_o = vs_q;
  assign snap_o = '{day_secs: day_secs_q, nanos: nanos_q, error: error_q, bad: bad_q};

`ifndef ASSERT_OFF
  a_day_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    day_secs_q <= SECS_PER_DAY)
    else $error("day seconds beyond one day");

  a_nanos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nanos_q < NS_PER_SEC)
    else $error("nanoseconds not below one second");

  a_error_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    error_q == (|bad_q))
    else $error("error flag disagrees with range flags");

  a_error_clear_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    error_q |-> (day_secs_q == '0 && nanos_q == '0))
    else $error("time not cleared while in error");

  a_error_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && error_q && upd_i.cmd != CMD_LOAD) |=>
      ($stable(day_secs_q) && $stable(nanos_q) && $stable(bad_q)))
    else $error("delta applied while in error");
`endif

endmodule

@@ rtl/tda_format.sv @@
module tda_format (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            snap_valid_i,
  output logic            snap_ready_o,
  input  tda_pkg::snap_t  snap_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output tda_pkg::res_t   res_o
);
  import tda_pkg::*;

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  snap_t       s1_q, s2_q, s3_q;
  logic [4:0]  hour1_q, hour2_q, hour3_q;
  logic [11:0] rh2_q, rh3_q;
  logic [5:0]  min3_q;
  res_t        res4_q;

  assign rdy4 = !v4_q || res_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign snap_ready_o = rdy1;
  assign res_valid_o = v4_q;
  assign res_o = res4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= snap_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  logic [35:0]      hour_prod;
  logic [SecsW-1:0] hour_secs;
  logic [SecsW-1:0] rh_full;
  logic [24:0]      min_prod;
  logic [11:0]      min_secs;
  logic [11:0]      sec_full;

  always_comb begin
    hour_prod = 36'(snap_i.day_secs) * 36'(RECIP_3600);
    hour_secs = SecsW'(hour1_q) * SecsW'(SECS_PER_HOUR);
    rh_full = s1_q.day_secs - hour_secs;
    min_prod = 25'(rh2_q) * 25'(RECIP_60);
    // minute * 60 as (minute << 6) - (minute << 2)
    min_secs = (12'(min3_q) << 6) - (12'(min3_q) << 2);
    sec_full = rh3_q - min_secs;
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_q    <= snap_i;
      hour1_q <= hour_prod[Recip3600Sh+4:Recip3600Sh];
    end
    if (rdy2) begin
      s2_q    <= s1_q;
      hour2_q <= hour1_q;
      rh2_q   <= rh_full[11:0];
    end
    if (rdy3) begin
      s3_q    <= s2_q;
      hour3_q <= hour2_q;
      rh3_q   <= rh2_q;
      min3_q  <= min_prod[Recip60Sh+5:Recip60Sh];
    end
    if (rdy4) begin
      res4_q.hour   <= hour3_q;
      res4_q.minute <= min3_q;
      res4_q.sec    <= sec_full[5:0];
      res4_q.nanos  <= s3_q.nanos;
      res4_q.error  <= s3_q.error;
      res4_q.bad    <= s3_q.bad;
    end
  end

endmodule

@@ rtl/time_of_day_accumulator.sv @@
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser command, tdata load fields and delta
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata time of day and range flags
//
// One item per clock sustained while m_axis_tready stays high; the time state is updated
// from a delta that was already reduced mod one day and mod one second upstream.
// From input transfer to result valid, four stages reduce the delta, one updates the
// time state, and four split seconds into hour, minute, second.
// Reset clears the time, the flags and all stage valids; no clearing pass.
// A stall on m_axis fills the bubbles first, then holds s_axis_tready low.
module time_of_day_accumulator (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [4:0] load_hour, [10:5] load_minute, [16:11] load_second,
  // [46:17] load_nanosecond, [78:47] delta_secs, [109:79] delta_nanos, [111:110] zero
  input  logic [111:0] s_axis_tdata,
  // [1:0] command
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [4:0] hour, [10:5] minute, [16:11] sec, [46:17] nanosecond, [47] error,
  // [48] hour_bad, [49] minute_bad, [50] second_bad, [51] nanosecond_bad, [55:52] zero
  output logic [55:0]  m_axis_tdata
);
  import tda_pkg::*;

  logic  upd_valid, upd_ready;
  upd_t  upd;
  logic  snap_valid, snap_ready;
  snap_t snap;
  res_t  res;

  tda_prep u_prep (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (s_axis_tvalid),
    .in_ready_o        (s_axis_tready),
    .cmd_i             (cmd_e'(s_axis_tuser)),
    .load_hour_i       (s_axis_tdata[4:0]),
    .load_minute_i     (s_axis_tdata[10:5]),
    .load_second_i     (s_axis_tdata[16:11]),
    .load_nanosecond_i (s_axis_tdata[46:17]),
    .delta_secs_i      (s_axis_tdata[78:47]),
    .delta_nanos_i     (s_axis_tdata[109:79]),
    .upd_valid_o       (upd_valid),
    .upd_ready_i       (upd_ready),
    .upd_o             (upd)
  );

  tda_state u_state (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .upd_valid_i  (upd_valid),
    .upd_ready_o  (upd_ready),
    .upd_i        (upd),
    .snap_valid_o (snap_valid),
    .snap_ready_i (snap_ready),
    .snap_o       (snap)
  );

  tda_format u_format (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (snap_valid),
    .snap_ready_o (snap_ready),
    .snap_i       (snap),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  assign m_axis_tdata = {4'd0, res.bad[3], res.bad[2], res.bad[1], res.bad[0], res.error,
                         res.nanos, res.sec, res.minute, res.hour};

endmodule
